// ===== hdl/lattice_occupancy_pair_counter_unit_macros.svh =====
// assertion macros shared by the lattice pair counter rtl
`ifndef LATTICE_OCCUPANCY_PAIR_COUNTER_UNIT_MACROS_SVH
`define LATTICE_OCCUPANCY_PAIR_COUNTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// concurrent check on a given clock, skipped while reset is low
`define LOPC_ASSERT_CR(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lopc assertion failed");

// concurrent check on the unit clock and reset
`define LOPC_ASSERT(label, prop) \
    `LOPC_ASSERT_CR(label, i_clk, i_rst_n, prop)

`else

`define LOPC_ASSERT_CR(label, clk, rst_n, prop)
`define LOPC_ASSERT(label, prop)

`endif

`endif

// ===== hdl/lopc_pkg.sv =====
// shared types and constants of the lattice pair counter
package lopc_pkg;

    // fixed field widths
    localparam int FUNC_W  = 3;
    localparam int COORD_W = 6;
    localparam int CRD_W   = 7;
    localparam int SPC_W   = 4;
    localparam int STAT_W  = 2;
    localparam int PAIR_W  = 17;
    localparam int TAL_W   = 16;
    localparam int BOX_W   = 6;

    // parameter defaults
    localparam int SIDE_MAX_DEF    = 32;
    localparam int SPECIES_MAX_DEF = 16;

    // reset value and saturation limits
    localparam logic [BOX_W-1:0]  BOX_RESET = 6'd32;
    localparam logic [TAL_W-1:0]  TAL_MAX   = 16'hFFFF;
    localparam logic [PAIR_W-1:0] PAIR_MAX  = 17'h1FFFF;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PLACE  = 3'd0,
        FN_REMOVE = 3'd1,
        FN_LOOKUP = 3'd2,
        FN_COUNT  = 3'd3,
        FN_CLEAR  = 3'd4
    } t_func;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_SPECIES = 2'd3
    } t_status;

endpackage

// ===== hdl/lopc_ram.sv =====
// generic single write port ram with registered read
module lopc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lattice_occupancy_pair_counter_unit.sv =====
// lattice occupancy store with nearest neighbor pair counter, top level
//
// channel  | dir | handshake                    | payload
// ---------+-----+------------------------------+----------------------------------------
// in       | in  | i_in_valid / o_in_ready      | func, site_x/y/z, species_a/b
// out      | out | o_out_valid / i_out_ready    | status, site_species, pair_count, total
// cfg      | in  | i_cfg_we                     | i_cfg_data (box size)
//
// place, remove and look up run through accept, site and tally read, occupant
// tally read, then read-modify-write of the site table and tally memories
// count makes seven site table reads per site, the site and its six neighbors,
// then drains the last read
// clear sweeps all SIDE_MAX^3 site table entries, one entry written per cycle
// after reset the site table is swept to empty, all SIDE_MAX^3 entries (32768 at
// the default size), with o_in_ready low; the tally has a valid bit per entry
// a result waits in the output register while the next item is accepted
`include "lattice_occupancy_pair_counter_unit_macros.svh"

module lattice_occupancy_pair_counter_unit import lopc_pkg::*; #(
    parameter int SIDE_MAX    = SIDE_MAX_DEF,
    parameter int SPECIES_MAX = SPECIES_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [BOX_W-1:0]   i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [COORD_W-1:0] i_site_x,
    input  logic [COORD_W-1:0] i_site_y,
    input  logic [COORD_W-1:0] i_site_z,
    input  logic [SPC_W-1:0]   i_species_a,
    input  logic [SPC_W-1:0]   i_species_b,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [SPC_W-1:0]   o_site_species,
    output logic [PAIR_W-1:0]  o_pair_count,
    output logic [TAL_W-1:0]   o_species_total
);

    localparam int N_SITES = SIDE_MAX * SIDE_MAX * SIDE_MAX;
    localparam int ADDR_W  = $clog2(N_SITES);
    localparam int TI_W    = $clog2(SPECIES_MAX);
    localparam int ACC_W   = $clog2(6 * N_SITES + 1);
    localparam int CMP_W   = (ACC_W > PAIR_W) ? ACC_W : PAIR_W;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(N_SITES - 1);
    localparam logic [CRD_W-1:0]  SIDE_CRD  = CRD_W'(SIDE_MAX);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CRD_W-1:0]  t_crd;
    typedef logic [TI_W-1:0]   t_tidx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SITE,
        S_TALLY,
        S_COUNT,
        S_DRAIN,
        S_EXEC,
        S_CLEAR
    } t_state;

    // which face neighbor the count sequencer reads
    typedef enum logic [2:0] {
        NB_SELF,
        NB_XP,
        NB_XM,
        NB_YP,
        NB_YM,
        NB_ZP,
        NB_ZM
    } t_nbr;

    // helpers
    function automatic logic usable(input logic [SPC_W-1:0] sp);
        return (sp != '0) && (int'(sp) < SPECIES_MAX);
    endfunction

    function automatic logic in_box(input t_crd c, input t_crd b);
        return (c != '0) && (c <= b);
    endfunction

    function automatic t_addr site_addr(input t_crd x, input t_crd y, input t_crd z);
        return ADDR_W'((int'(x) - 1) * SIDE_MAX * SIDE_MAX
                       + (int'(y) - 1) * SIDE_MAX + (int'(z) - 1));
    endfunction

    // registers
    t_state              r_state;
    logic [BOX_W-1:0]    r_box_size;
    t_func               r_func;
    logic [COORD_W-1:0]  r_x, r_y, r_z;
    logic [SPC_W-1:0]    r_sa, r_sb;
    logic                r_inbox;
    logic [SPC_W-1:0]    r_occ;
    logic [TAL_W-1:0]    r_tsa;
    logic                r_tv_hit;
    logic [SPECIES_MAX-1:0] r_tvalid;
    t_addr               r_addr;
    logic                r_clr_rpt;
    t_crd                r_cx, r_cy, r_cz;
    t_nbr                r_k;
    logic                r_tag_vld, r_tag_nb, r_tag_ok;
    logic                r_cmatch;
    logic [ACC_W-1:0]    r_acc;
    logic                r_out_valid;
    t_status             r_status;
    logic [SPC_W-1:0]    r_found;
    logic [PAIR_W-1:0]   r_pairs;
    logic [TAL_W-1:0]    r_total;

    // next result values
    t_status             n_status;
    logic [SPC_W-1:0]    n_found;
    logic [PAIR_W-1:0]   n_pairs;
    logic [TAL_W-1:0]    n_total;

    // combinational signals
    t_crd                box_eff;
    logic                accept, out_free, fire;
    t_crd                rx, ry, rz;
    t_crd                nb_x, nb_y, nb_z;
    logic                nb_ok;
    t_addr               cur_addr;
    logic                site_re, site_we;
    t_addr               site_raddr, site_waddr;
    logic [SPC_W-1:0]    site_wdata, site_q;
    logic                tal_re, tal_we;
    t_tidx               tal_raddr, tal_waddr;
    logic [TAL_W-1:0]    tal_wdata, tal_rdata, tal_q;
    logic [TAL_W-1:0]    tocc, tal_inc, tal_dec;
    logic                ex_site_we, ex_tal_we;
    logic [SPC_W-1:0]    ex_site_wdata;
    t_tidx               ex_tal_waddr;
    logic [TAL_W-1:0]    ex_tal_wdata;
    logic [ACC_W-1:0]    acc_half;
    logic [CMP_W-1:0]    acc_wide;
    logic [PAIR_W-1:0]   pair_sat;
    logic                lk_match;

    // effective box edge, clamped to 1..SIDE_MAX
    always_comb begin
        if (r_box_size == '0) begin
            box_eff = t_crd'(1);
        end else if (CRD_W'(r_box_size) > SIDE_CRD) begin
            box_eff = SIDE_CRD;
        end else begin
            box_eff = CRD_W'(r_box_size);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = (r_state == S_EXEC) && out_free;

    assign rx       = CRD_W'(r_x);
    assign ry       = CRD_W'(r_y);
    assign rz       = CRD_W'(r_z);
    assign cur_addr = site_addr(rx, ry, rz);

    // neighbor coordinates for the count sequencer
    always_comb begin
        nb_x = r_cx;
        nb_y = r_cy;
        nb_z = r_cz;
        case (r_k)
            NB_XP:   nb_x = r_cx + t_crd'(1);
            NB_XM:   nb_x = r_cx - t_crd'(1);
            NB_YP:   nb_y = r_cy + t_crd'(1);
            NB_YM:   nb_y = r_cy - t_crd'(1);
            NB_ZP:   nb_z = r_cz + t_crd'(1);
            NB_ZM:   nb_z = r_cz - t_crd'(1);
            default: ;
        endcase
    end

    assign nb_ok = in_box(nb_x, box_eff) && in_box(nb_y, box_eff) && in_box(nb_z, box_eff);

    // site table read port
    assign site_re = (r_state == S_SITE) || (r_state == S_COUNT);
    always_comb begin
        site_raddr = '0;
        if (r_state == S_COUNT) begin
            site_raddr = nb_ok ? site_addr(nb_x, nb_y, nb_z) : site_addr(r_cx, r_cy, r_cz);
        end else if (r_inbox) begin
            site_raddr = cur_addr;
        end
    end

    // tally read port: species_a first, then the occupant
    assign tal_re = (r_state == S_SITE) || (r_state == S_TALLY);
    always_comb begin
        tal_raddr = '0;
        if (r_state == S_TALLY) begin
            if (usable(site_q)) begin
                tal_raddr = TI_W'(site_q);
            end
        end else if (usable(r_sa)) begin
            tal_raddr = TI_W'(r_sa);
        end
    end

    // an entry never written reads as zero
    assign tal_q   = r_tv_hit ? tal_rdata : '0;
    assign tocc    = usable(r_occ) ? tal_q : '0;
    assign tal_inc = (r_tsa == TAL_MAX) ? r_tsa : r_tsa + TAL_W'(1);
    assign tal_dec = (tocc == '0) ? tocc : tocc - TAL_W'(1);

    // halve for a like pair, then saturate
    assign acc_half = (r_sa == r_sb) ? (r_acc >> 1) : r_acc;
    assign acc_wide = CMP_W'(acc_half);
    assign pair_sat = (acc_wide > CMP_W'(PAIR_MAX)) ? PAIR_MAX : PAIR_W'(acc_wide);

    assign lk_match = (r_occ != '0) && ((r_sa == '0) || (usable(r_sa) && (r_occ == r_sa)));

    // result and write-back of the current item
    always_comb begin
        n_status      = ST_OK;
        n_found       = '0;
        n_pairs       = '0;
        n_total       = '0;
        ex_site_we    = 1'b0;
        ex_site_wdata = '0;
        ex_tal_we     = 1'b0;
        ex_tal_waddr  = '0;
        ex_tal_wdata  = '0;
        case (r_func)
            FN_PLACE: begin
                if (!r_inbox) begin
                    n_status = ST_OUTSIDE;
                end else if (!usable(r_sa)) begin
                    n_status = ST_SPECIES;
                end else if (r_occ != '0) begin
                    n_status = ST_MISS;
                    n_found  = r_occ;
                    n_total  = r_tsa;
                end else begin
                    ex_site_we    = 1'b1;
                    ex_site_wdata = r_sa;
                    ex_tal_we     = 1'b1;
                    ex_tal_waddr  = TI_W'(r_sa);
                    ex_tal_wdata  = tal_inc;
                    n_found       = r_sa;
                    n_total       = tal_inc;
                end
            end
            FN_REMOVE: begin
                if (!r_inbox) begin
                    n_status = ST_OUTSIDE;
                end else if (r_occ == '0) begin
                    n_status = ST_MISS;
                end else begin
                    ex_site_we   = 1'b1;
                    ex_tal_we    = usable(r_occ) && (tocc != '0);
                    ex_tal_waddr = TI_W'(r_occ);
                    ex_tal_wdata = tal_dec;
                    n_found      = r_occ;
                    n_total      = tal_dec;
                end
            end
            FN_LOOKUP: begin
                if (!r_inbox) begin
                    n_status = ST_OUTSIDE;
                end else if (lk_match) begin
                    n_found = r_occ;
                    n_total = tocc;
                end else begin
                    n_status = ST_MISS;
                    n_total  = r_tsa;
                end
            end
            FN_COUNT: begin
                if (!usable(r_sa) || !usable(r_sb)) begin
                    n_status = ST_SPECIES;
                end else begin
                    n_pairs = pair_sat;
                    n_total = r_tsa;
                end
            end
            default: ;
        endcase
    end

    // write ports: clearing sweep or item write-back
    always_comb begin
        site_we    = 1'b0;
        site_waddr = cur_addr;
        site_wdata = ex_site_wdata;
        if (r_state == S_CLEAR) begin
            site_we    = 1'b1;
            site_waddr = r_addr;
            site_wdata = '0;
        end else if (fire) begin
            site_we = ex_site_we;
        end
    end

    assign tal_we    = fire && ex_tal_we;
    assign tal_waddr = ex_tal_waddr;
    assign tal_wdata = ex_tal_wdata;

    // memories
    lopc_ram #(
        .WIDTH (SPC_W),
        .DEPTH (N_SITES)
    ) u_site_ram (
        .i_clk   (i_clk),
        .i_we    (site_we),
        .i_waddr (site_waddr),
        .i_wdata (site_wdata),
        .i_re    (site_re),
        .i_raddr (site_raddr),
        .o_rdata (site_q)
    );

    lopc_ram #(
        .WIDTH (TAL_W),
        .DEPTH (SPECIES_MAX)
    ) u_tally_ram (
        .i_clk   (i_clk),
        .i_we    (tal_we),
        .i_waddr (tal_waddr),
        .i_wdata (tal_wdata),
        .i_re    (tal_re),
        .i_raddr (tal_raddr),
        .o_rdata (tal_rdata)
    );

    // state machine, count pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_clr_rpt   <= 1'b0;
            r_box_size  <= BOX_RESET;
            r_out_valid <= 1'b0;
            r_tvalid    <= '0;
            r_tag_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_box_size <= i_cfg_data;
            end

            // count reads in flight, evaluated in the cycle after issue
            r_tag_vld <= (r_state == S_COUNT);
            r_tag_nb  <= (r_k != NB_SELF);
            r_tag_ok  <= nb_ok;
            if (r_tag_vld) begin
                if (!r_tag_nb) begin
                    r_cmatch <= (site_q == r_sa);
                end else if (r_cmatch && r_tag_ok && (site_q == r_sb)) begin
                    r_acc <= r_acc + ACC_W'(1);
                end
            end

            // tally valid bits
            if (tal_re) begin
                r_tv_hit <= r_tvalid[tal_raddr];
            end
            if (tal_we) begin
                r_tvalid[tal_waddr] <= 1'b1;
            end

            // output register
            if (fire) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_found     <= n_found;
                r_pairs     <= n_pairs;
                r_total     <= n_total;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func  <= t_func'(i_func);
                        r_x     <= i_site_x;
                        r_y     <= i_site_y;
                        r_z     <= i_site_z;
                        r_sa    <= i_species_a;
                        r_sb    <= i_species_b;
                        r_inbox <= in_box(CRD_W'(i_site_x), box_eff)
                                && in_box(CRD_W'(i_site_y), box_eff)
                                && in_box(CRD_W'(i_site_z), box_eff);
                        r_state <= S_SITE;
                    end
                end
                S_SITE: begin
                    if (r_func == FN_CLEAR) begin
                        r_addr    <= '0;
                        r_clr_rpt <= 1'b1;
                        r_state   <= S_CLEAR;
                    end else begin
                        r_state <= S_TALLY;
                    end
                end
                S_TALLY: begin
                    r_occ <= site_q;
                    r_tsa <= usable(r_sa) ? tal_q : '0;
                    if ((r_func == FN_COUNT) && usable(r_sa) && usable(r_sb)) begin
                        r_cx    <= t_crd'(1);
                        r_cy    <= t_crd'(1);
                        r_cz    <= t_crd'(1);
                        r_k     <= NB_SELF;
                        r_acc   <= '0;
                        r_state <= S_COUNT;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_COUNT: begin
                    if (r_k == NB_ZM) begin
                        r_k <= NB_SELF;
                        if (r_cz == box_eff) begin
                            r_cz <= t_crd'(1);
                            if (r_cy == box_eff) begin
                                r_cy <= t_crd'(1);
                                if (r_cx == box_eff) begin
                                    r_state <= S_DRAIN;
                                end else begin
                                    r_cx <= r_cx + t_crd'(1);
                                end
                            end else begin
                                r_cy <= r_cy + t_crd'(1);
                            end
                        end else begin
                            r_cz <= r_cz + t_crd'(1);
                        end
                    end else begin
                        r_k <= t_nbr'(3'(r_k) + 3'd1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    if (r_addr == ADDR_LAST) begin
                        r_state <= r_clr_rpt ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_site_species  = r_found;
    assign o_pair_count    = r_pairs;
    assign o_species_total = r_total;

    // checks
    `LOPC_ASSERT(a_idle_no_count_read, (r_state == S_IDLE) |-> !r_tag_vld)
    `LOPC_ASSERT(a_accept_starts_item, (i_in_valid && o_in_ready) |=> (r_state == S_SITE))
    `LOPC_ASSERT(a_pairs_only_on_ok, (o_out_valid && (o_pair_count != '0)) |-> ((o_status == ST_OK) && (o_site_species == '0)))
    `LOPC_ASSERT(a_no_write_while_idle, (r_state == S_IDLE) |-> (!site_we && !tal_we))

endmodule
